FILE: src/kda_pkg.sv
// ----------------------------------------------------------------------------
// kda_pkg
// shared widths, reset values, register indexes and lane/merge types
// ----------------------------------------------------------------------------
package kda_pkg;

  localparam int unsigned NUM_KEYS_DEF = 4;
  localparam int unsigned LEVEL_W      = 4;   // keys with a level input
  localparam int unsigned MASK_W       = 4;   // keys with a repeat mask bit
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned ADDR_W       = 2;
  localparam int unsigned EVENT_W      = 3;
  localparam int unsigned IN_DATA_W    = 40;  // 36 payload bits padded to bytes
  localparam int unsigned OUT_DATA_W   = 8;

  localparam logic [CFG_W-1:0]  DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0]  DELAY_RST    = 16'd500;
  localparam logic [CFG_W-1:0]  INTERVAL_RST = 16'd100;
  localparam logic [MASK_W-1:0] MASK_RST     = 4'd3;

  localparam logic [EVENT_W-1:0] EVENT_NONE = '0;
  localparam logic [EVENT_W-1:0] EVENT_MAX  = EVENT_W'(MASK_W);

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [ADDR_W-1:0] REG_DELAY    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_INTERVAL = 2'd2;
  localparam logic [ADDR_W-1:0] REG_MASK     = 2'd3;

  // what one lane found for its key on this scan
  typedef struct packed {
    logic press;     // becomes stably pressed now
    logic rpt;       // qualifies for an auto-repeat event
  } lane_flags_t;

  // what the merge stage lets each key do
  typedef struct packed {
    logic commit;        // key was sampled on this scan
    logic stamp_press;   // take press and repeat stamps
    logic stamp_repeat;  // take repeat stamp
  } key_ctl_t;

endpackage

FILE: src/kda_lane.sv
// ----------------------------------------------------------------------------
// kda_lane
// one key: raw level latch, debounce check and repeat qualification
// ----------------------------------------------------------------------------
module kda_lane
  import kda_pkg::*;
(
  input  logic [TIME_W-1:0] now_ms,
  input  logic              level,
  input  logic              may_repeat,
  input  logic [CFG_W-1:0]  debounce_ms,
  input  logic [CFG_W-1:0]  repeat_delay_ms,
  input  logic [CFG_W-1:0]  repeat_interval_ms,
  input  logic              raw_r,
  input  logic              stable_r,
  input  logic [TIME_W-1:0] change_r,
  input  logic [TIME_W-1:0] press_r,
  input  logic [TIME_W-1:0] repeat_r,
  output logic              raw_nxt,
  output logic              stable_nxt,
  output logic [TIME_W-1:0] change_nxt,
  output lane_flags_t       flags
);

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_repeat;
  logic              settle;

  always_comb begin
    raw_nxt      = level;
    change_nxt   = (level != raw_r) ? now_ms : change_r;
    since_change = now_ms - change_nxt;
    since_press  = now_ms - press_r;
    since_repeat = now_ms - repeat_r;
    settle       = (stable_r != raw_nxt) && (since_change >= TIME_W'(debounce_ms));
    stable_nxt   = settle ? raw_nxt : stable_r;
    flags.press  = settle && raw_nxt;
    // stable level after a possible release decides repeat eligibility
    flags.rpt    = may_repeat && stable_nxt &&
                   (since_press >= TIME_W'(repeat_delay_ms)) &&
                   (since_repeat >= TIME_W'(repeat_interval_ms));
  end

endmodule

FILE: src/kda_merge.sv
// ----------------------------------------------------------------------------
// kda_merge
// priority pick over the lanes: first press ends the scan, else first repeat
// ----------------------------------------------------------------------------
module kda_merge
  import kda_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  lane_flags_t [NUM_KEYS-1:0] flags,
  output key_ctl_t    [NUM_KEYS-1:0] ctl,
  output logic        [EVENT_W-1:0]  key_event
);

  logic any_press;
  logic blocked;
  logic rpt_taken;

  always_comb begin
    any_press = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      any_press = any_press | flags[k].press;
    end

    blocked   = 1'b0;
    rpt_taken = 1'b0;
    key_event = EVENT_NONE;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ctl[k].commit       = !blocked;
      ctl[k].stamp_press  = !blocked && flags[k].press;
      ctl[k].stamp_repeat = !any_press && !rpt_taken && flags[k].rpt;
      if (ctl[k].stamp_press || ctl[k].stamp_repeat) begin
        key_event = EVENT_W'(k + 1);
      end
      blocked   = blocked | flags[k].press;
      rpt_taken = rpt_taken | ctl[k].stamp_repeat;
    end
  end

endmodule

FILE: src/key_debounce_auto_repeat.sv
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat
// key debounce with press events and auto-repeat, one scan per item
// ----------------------------------------------------------------------------
// Each input item is one scan: a 32-bit millisecond time and the raw levels
// of the keys. One lane per key latches level changes with their time, checks
// the debounce interval and the repeat timing, all with wrapping 32-bit time
// differences; a merge stage then picks the lowest key that became stably
// pressed (keys above it are left untouched on that scan) or, without a press,
// the lowest masked held key due for a repeat. Every item produces exactly one
// result item; key_event 0 means no event. The whole scan is evaluated in the
// cycle the item is accepted; the critical path is the lane's 32-bit subtract
// and compare followed by the priority pick. A new item can be taken every
// cycle, also while a result waits, until the two-entry output buffer (output
// register plus skid stage) is full. Configuration writes take effect on the
// next scan and should be made while the block is idle.
// ----------------------------------------------------------------------------
module key_debounce_auto_repeat
  import kda_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // scan items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms, [35:32] key_levels
  // events
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] key_event
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // config registers
  logic [CFG_W-1:0]  debounce_r;
  logic [CFG_W-1:0]  delay_r;
  logic [CFG_W-1:0]  interval_r;
  logic [MASK_W-1:0] mask_r;

  // per-key state
  logic [NUM_KEYS-1:0] raw_r;
  logic [NUM_KEYS-1:0] stable_r;
  logic [TIME_W-1:0]   change_r [NUM_KEYS];
  logic [TIME_W-1:0]   press_r  [NUM_KEYS];
  logic [TIME_W-1:0]   repeat_r [NUM_KEYS];

  // lane results
  logic [NUM_KEYS-1:0]         raw_nxt;
  logic [NUM_KEYS-1:0]         stable_nxt;
  logic [TIME_W-1:0]           change_nxt [NUM_KEYS];
  lane_flags_t [NUM_KEYS-1:0]  flags;
  key_ctl_t    [NUM_KEYS-1:0]  ctl;
  logic [EVENT_W-1:0]          key_event;
  logic [NUM_KEYS-1:0]         grant;

  // output buffer
  logic               out_valid_r;
  logic [EVENT_W-1:0] out_event_r;
  logic               skid_valid_r;
  logic [EVENT_W-1:0] skid_event_r;

  logic [TIME_W-1:0]  now_ms;
  logic [LEVEL_W-1:0] key_levels;
  logic               accept;
  logic               out_free;

  assign now_ms     = in_tdata[TIME_W-1:0];
  assign key_levels = in_tdata[TIME_W +: LEVEL_W];
  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-EVENT_W){1'b0}}, out_event_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      delay_r    <= DELAY_RST;
      interval_r <= INTERVAL_RST;
      mask_r     <= MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DEBOUNCE: debounce_r <= cfg_wdata;
        REG_DELAY:    delay_r    <= cfg_wdata;
        REG_INTERVAL: interval_r <= cfg_wdata;
        REG_MASK:     mask_r     <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // one lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    logic may_repeat;

    // keys without an input bit read released, without a mask bit never repeat
    if (k < LEVEL_W) begin : g_lvl
      assign level = key_levels[k];
    end else begin : g_nolvl
      assign level = 1'b0;
    end
    if (k < MASK_W) begin : g_msk
      assign may_repeat = mask_r[k];
    end else begin : g_nomsk
      assign may_repeat = 1'b0;
    end

    kda_lane u_lane (
      .now_ms             (now_ms),
      .level              (level),
      .may_repeat         (may_repeat),
      .debounce_ms        (debounce_r),
      .repeat_delay_ms    (delay_r),
      .repeat_interval_ms (interval_r),
      .raw_r              (raw_r[k]),
      .stable_r           (stable_r[k]),
      .change_r           (change_r[k]),
      .press_r            (press_r[k]),
      .repeat_r           (repeat_r[k]),
      .raw_nxt            (raw_nxt[k]),
      .stable_nxt         (stable_nxt[k]),
      .change_nxt         (change_nxt[k]),
      .flags              (flags[k])
    );

    // levels reset to released; stamps are read only after being written
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        raw_r[k]    <= 1'b0;
        stable_r[k] <= 1'b0;
      end else if (accept && ctl[k].commit) begin
        raw_r[k]    <= raw_nxt[k];
        stable_r[k] <= stable_nxt[k];
      end
    end

    always_ff @(posedge clk) begin
      if (accept && ctl[k].commit) begin
        change_r[k] <= change_nxt[k];
      end
      if (accept && ctl[k].stamp_press) begin
        press_r[k] <= now_ms;
      end
      if (accept && (ctl[k].stamp_press || ctl[k].stamp_repeat)) begin
        repeat_r[k] <= now_ms;
      end
    end
  end

  kda_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .flags     (flags),
    .ctl       (ctl),
    .key_event (key_event)
  );

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_event_r  <= skid_event_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
        if (accept) begin
          out_event_r <= key_event;
        end
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
      skid_event_r <= key_event;
    end
  end

  // per-key event grant, press or repeat
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      grant[k] = ctl[k].stamp_press || ctl[k].stamp_repeat;
    end
  end

  // skid stage only fills behind a held output
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // key state moves only on an accepted scan
  assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(stable_r) && $stable(raw_r)))
    else $error("key state changed without a scan");

  // a scan grants at most one event
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> $onehot0(grant))
    else $error("more than one key granted");

  // event codes stay within the keys that can fire
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_r <= EVENT_MAX))
    else $error("event code out of range");

  // a held result is not overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_event_r)))
    else $error("stalled result changed");

endmodule
